// ===== src/bpg_pkg.sv =====
// package: types and constants for the beep pattern generator
`timescale 1ns / 1ps

package bpg_pkg;

    localparam int TICK_PERIOD_W = 10;
    localparam int ELAPSED_W     = 18;
    localparam int DURATION_W    = 16;
    localparam int CYCLE_W       = DURATION_W + 1;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = TICK_PERIOD_W;

    localparam logic [TICK_PERIOD_W-1:0] TICK_PERIOD_RESET = TICK_PERIOD_W'(10);
    localparam logic [DURATION_W-1:0]    PITCH_RESET       = DURATION_W'(2000);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TICK_PERIOD     = 2'd0,
        CFG_CHANGES_ENABLED = 2'd1
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } operation_t;

    typedef enum logic [3:0] {
        STAGE_PENDING  = 4'b0001,
        STAGE_WAIT_OFF = 4'b0010,
        STAGE_WAIT_END = 4'b0100,
        STAGE_IDLE     = 4'b1000
    } stage_t;

    typedef struct packed {
        logic                  tone_enable;
        logic [DURATION_W-1:0] tone_hz;
        logic                  busy_res;
        logic                  accepted;
    } result_t;

endpackage

// ===== src/beep_pattern_generator.sv =====
// top level: buzzer on/off pattern timer with a two-entry result queue
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    operation, durations, repeat count, frequency
//  m_        out        m_valid / m_ready    tone enable, tone hz, busy, accepted
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// one item per cycle while s_ready is high; the state update is one add, compare and subtract
// on the elapsed counter, done in the cycle an item is accepted
// the result lands in a two-entry queue, so s_ready stays high while one
// result waits on a stalled m_ready; s_ready drops only when both are full
// aresetn is synchronous, active low; it empties the queue and restores
// the idle stage, tick period 10, changes enabled and pitch 2000
`timescale 1ns / 1ps

module beep_pattern_generator (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [bpg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_operation,
    input  logic [bpg_pkg::DURATION_W-1:0]   s_on_duration,
    input  logic [bpg_pkg::DURATION_W-1:0]   s_off_duration,
    input  logic [bpg_pkg::DURATION_W-1:0]   s_repeat_count,
    input  logic [bpg_pkg::DURATION_W-1:0]   s_tone_frequency,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_tone_enable,
    output logic [bpg_pkg::DURATION_W-1:0]   m_tone_hz,
    output logic                             m_busy_res,
    output logic                             m_accepted
);
    import bpg_pkg::*;

    logic [TICK_PERIOD_W-1:0] tick_period_reg;
    logic                     changes_enabled_reg;

    stage_t                   stage_reg, stage_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [DURATION_W-1:0]    on_length_reg, on_length_next;
    logic [DURATION_W-1:0]    off_length_reg, off_length_next;
    logic [CYCLE_W-1:0]       cycle_reg, cycle_next;
    logic [DURATION_W-1:0]    beeps_left_reg, beeps_left_next;
    logic [DURATION_W-1:0]    pitch_reg, pitch_next;
    logic                     sounding_reg, sounding_next;

    result_t                  queue_reg [2];
    logic                     wr_ptr_reg, rd_ptr_reg;
    logic [1:0]               count_reg;

    logic                     push, pop;
    logic                     took;
    logic [ELAPSED_W-1:0]     elapsed_sum;
    result_t                  result;
    result_t                  head;

    assign push = s_valid && s_ready;
    assign pop  = m_valid && m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg     <= TICK_PERIOD_RESET;
            changes_enabled_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TICK_PERIOD:     tick_period_reg     <= cfg_wdata;
                CFG_CHANGES_ENABLED: changes_enabled_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign elapsed_sum = elapsed_reg + ELAPSED_W'(tick_period_reg);

    always_comb begin
        stage_next      = stage_reg;
        elapsed_next    = elapsed_reg;
        on_length_next  = on_length_reg;
        off_length_next = off_length_reg;
        cycle_next      = cycle_reg;
        beeps_left_next = beeps_left_reg;
        pitch_next      = pitch_reg;
        sounding_next   = sounding_reg;
        took            = 1'b0;

        if (s_operation == OP_START) begin
            if (changes_enabled_reg) begin
                on_length_next  = s_on_duration;
                off_length_next = s_off_duration;
                cycle_next      = CYCLE_W'(s_on_duration) + CYCLE_W'(s_off_duration);
                beeps_left_next = s_repeat_count;
                pitch_next      = s_tone_frequency;
                stage_next      = STAGE_PENDING;
                took            = 1'b1;
            end
        end else begin
            unique case (stage_reg)
                STAGE_PENDING: begin
                    if (on_length_reg != '0) begin
                        sounding_next = 1'b1;
                        elapsed_next  = '0;
                        stage_next    = STAGE_WAIT_OFF;
                    end else begin
                        sounding_next = 1'b0;
                        stage_next    = STAGE_IDLE;
                    end
                end
                STAGE_WAIT_OFF: begin
                    elapsed_next = elapsed_sum;
                    if (elapsed_sum >= ELAPSED_W'(on_length_reg)) begin
                        sounding_next = 1'b0;
                        stage_next    = (off_length_reg != '0) ? STAGE_WAIT_END : STAGE_IDLE;
                    end
                end
                STAGE_WAIT_END: begin
                    elapsed_next = elapsed_sum;
                    if (elapsed_sum >= ELAPSED_W'(cycle_reg)) begin
                        // excess time carries into the next period
                        elapsed_next = elapsed_sum - ELAPSED_W'(cycle_reg);
                        if (beeps_left_reg == DURATION_W'(1)) begin
                            sounding_next = 1'b0;
                            stage_next    = STAGE_IDLE;
                        end else begin
                            sounding_next = 1'b1;
                            if (beeps_left_reg != '0) begin
                                beeps_left_next = beeps_left_reg - DURATION_W'(1);
                            end
                            stage_next = STAGE_WAIT_OFF;
                        end
                    end
                end
                STAGE_IDLE: ;
                default: ;
            endcase
        end

        result.tone_enable = sounding_next;
        result.tone_hz     = sounding_next ? pitch_next : '0;
        result.busy_res    = (stage_next != STAGE_IDLE);
        result.accepted    = took;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg      <= STAGE_IDLE;
            elapsed_reg    <= '0;
            on_length_reg  <= '0;
            off_length_reg <= '0;
            cycle_reg      <= '0;
            beeps_left_reg <= '0;
            pitch_reg      <= PITCH_RESET;
            sounding_reg   <= 1'b0;
        end else if (push) begin
            stage_reg      <= stage_next;
            elapsed_reg    <= elapsed_next;
            on_length_reg  <= on_length_next;
            off_length_reg <= off_length_next;
            cycle_reg      <= cycle_next;
            beeps_left_reg <= beeps_left_next;
            pitch_reg      <= pitch_next;
            sounding_reg   <= sounding_next;
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign s_ready = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);

    assign m_tone_enable = head.tone_enable;
    assign m_tone_hz     = head.tone_hz;
    assign m_busy_res    = head.busy_res;
    assign m_accepted    = head.accepted;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("result queue count out of range");

    a_taken_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_busy_res)
        else $error("taken start reported not busy");

    a_silent_no_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tone_enable |-> m_tone_hz == '0)
        else $error("pitch driven while silent");

    a_start_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_operation == OP_START && changes_enabled_reg
        |=> stage_reg == STAGE_PENDING)
        else $error("taken start did not enter pending stage");
`endif

endmodule

// ===== sim/tb_top.sv =====
// testbench for the beep pattern generator: random and directed items checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import bpg_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        operation_t            op;
        logic [DURATION_W-1:0] on_len;
        logic [DURATION_W-1:0] off_len;
        logic [DURATION_W-1:0] reps;
        logic [DURATION_W-1:0] hz;
    } beep_item_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_operation = 1'b0;
    logic [DURATION_W-1:0]   s_on_duration = '0;
    logic [DURATION_W-1:0]   s_off_duration = '0;
    logic [DURATION_W-1:0]   s_repeat_count = '0;
    logic [DURATION_W-1:0]   s_tone_frequency = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_tone_enable;
    logic [DURATION_W-1:0]   m_tone_hz;
    logic                    m_busy_res;
    logic                    m_accepted;

    // predictor state and register copies
    logic [TICK_PERIOD_W-1:0] period_cfg = TICK_PERIOD_RESET;
    logic                     starts_allowed = 1'b1;
    stage_t                   pat_stage = STAGE_IDLE;
    logic [ELAPSED_W-1:0]     time_count = '0;
    logic [DURATION_W-1:0]    on_time = '0;
    logic [DURATION_W-1:0]    gap_time = '0;
    logic [DURATION_W-1:0]    beeps_to_go = '0;
    logic [DURATION_W-1:0]    pattern_hz = PITCH_RESET;
    logic                     tone_on = 1'b0;

    beep_item_t beep_items[$];
    result_t    expected_tones[$];
    beep_item_t offered;
    result_t    want_tone;

    bit steady = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int failures = 0;
    int items_taken = 0;
    int results_seen = 0;
    int starts_taken = 0;
    int starts_refused = 0;
    int settings_used = 0;

    beep_pattern_generator uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_on_duration    (s_on_duration),
        .s_off_duration   (s_off_duration),
        .s_repeat_count   (s_repeat_count),
        .s_tone_frequency (s_tone_frequency),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tone_enable    (m_tone_enable),
        .m_tone_hz        (m_tone_hz),
        .m_busy_res       (m_busy_res),
        .m_accepted       (m_accepted)
    );

    always #10 aclk = ~aclk;

    function automatic result_t predict_beep(beep_item_t it);
        result_t              res;
        logic [CYCLE_W-1:0]   period_len;
        logic                 took;
        took = 1'b0;
        period_len = CYCLE_W'(on_time) + CYCLE_W'(gap_time);
        if (it.op == OP_START) begin
            if (starts_allowed) begin
                on_time = it.on_len;
                gap_time = it.off_len;
                beeps_to_go = it.reps;
                pattern_hz = it.hz;
                pat_stage = STAGE_PENDING;
                took = 1'b1;
                starts_taken++;
            end else begin
                starts_refused++;
            end
        end else begin
            case (pat_stage)
                STAGE_PENDING: begin
                    if (on_time != 0) begin
                        tone_on = 1'b1;
                        time_count = '0;
                        pat_stage = STAGE_WAIT_OFF;
                    end else begin
                        tone_on = 1'b0;
                        pat_stage = STAGE_IDLE;
                    end
                end
                STAGE_WAIT_OFF: begin
                    time_count = time_count + ELAPSED_W'(period_cfg);
                    if (time_count >= ELAPSED_W'(on_time)) begin
                        tone_on = 1'b0;
                        pat_stage = (gap_time != 0) ? STAGE_WAIT_END : STAGE_IDLE;
                    end
                end
                STAGE_WAIT_END: begin
                    time_count = time_count + ELAPSED_W'(period_cfg);
                    if (time_count >= ELAPSED_W'(period_len)) begin
                        // excess time carries into the next beep
                        time_count = time_count - ELAPSED_W'(period_len);
                        if (beeps_to_go == 1) begin
                            tone_on = 1'b0;
                            pat_stage = STAGE_IDLE;
                        end else begin
                            tone_on = 1'b1;
                            if (beeps_to_go != 0) beeps_to_go = beeps_to_go - DURATION_W'(1);
                            pat_stage = STAGE_WAIT_OFF;
                        end
                    end
                end
                default: ;
            endcase
        end
        res.tone_enable = tone_on;
        res.tone_hz = tone_on ? pattern_hz : '0;
        res.busy_res = (pat_stage != STAGE_IDLE);
        res.accepted = took;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [DURATION_W-1:0] want,
                               input logic [DURATION_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_tones.push_back(predict_beep(offered));
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (beep_items.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
                    offered = beep_items.pop_front();
                    s_operation <= offered.op;
                    s_on_duration <= offered.on_len;
                    s_off_duration <= offered.off_len;
                    s_repeat_count <= offered.reps;
                    s_tone_frequency <= offered.hz;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_tones.size() == 0) begin
                    $display("%0t: result with no item waiting, expected none, actual %b/%0d/%b/%b",
                             $time, m_tone_enable, m_tone_hz, m_busy_res, m_accepted);
                    failures++;
                end else begin
                    want_tone = expected_tones.pop_front();
                    check_field("tone_enable", DURATION_W'(want_tone.tone_enable),
                                DURATION_W'(m_tone_enable));
                    check_field("tone_hz", want_tone.tone_hz, m_tone_hz);
                    check_field("busy_res", DURATION_W'(want_tone.busy_res),
                                DURATION_W'(m_busy_res));
                    check_field("accepted", DURATION_W'(want_tone.accepted),
                                DURATION_W'(m_accepted));
                end
            end
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 14);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_item(input operation_t op, input logic [DURATION_W-1:0] on_len,
                              input logic [DURATION_W-1:0] off_len,
                              input logic [DURATION_W-1:0] reps,
                              input logic [DURATION_W-1:0] hz);
        beep_item_t it;
        it.op = op;
        it.on_len = on_len;
        it.off_len = off_len;
        it.reps = reps;
        it.hz = hz;
        beep_items.push_back(it);
    endtask

    task automatic queue_ticks(input int count);
        for (int i = 0; i < count; i++)
            queue_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // mostly ticks, with starts sized so that patterns run to their end often
    task automatic queue_patterns(input int count);
        beep_item_t it;
        int         span;
        int         roll;
        span = 4 * int'(period_cfg) + 4;
        for (int i = 0; i < count; i++) begin
            it.op = OP_TICK;
            it.on_len = 16'($urandom);
            it.off_len = 16'($urandom);
            it.reps = 16'($urandom);
            it.hz = 16'($urandom);
            if ($urandom_range(99) < 9) begin
                it.op = OP_START;
                if ($urandom_range(9) != 0) it.on_len = 16'($urandom_range(span));
                roll = $urandom_range(99);
                if (roll < 20) it.off_len = '0;
                else if (roll < 90) it.off_len = 16'($urandom_range(span));
                roll = $urandom_range(99);
                if (roll < 15) it.reps = '0;
                else if (roll < 75) it.reps = 16'($urandom_range(4, 1));
                else if (roll < 90) it.reps = 16'($urandom_range(20, 5));
            end
            beep_items.push_back(it);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (beep_items.size() != 0 || s_valid || expected_tones.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_TICK_PERIOD) period_cfg = data;
        else if (idx == CFG_CHANGES_ENABLED) starts_allowed = data[0];
    endtask

    task automatic set_regs(input logic [TICK_PERIOD_W-1:0] period, input logic enable);
        wait_drained();
        cfg_write(CFG_TICK_PERIOD, period);
        cfg_write(CFG_CHANGES_ENABLED, {9'($urandom), enable});
        @(negedge aclk);
        settings_used++;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        settings_used = 1;

        // directed, reset settings
        queue_ticks(1);
        queue_item(OP_START, 16'd0, 16'd5, 16'd1, 16'd1234);
        queue_ticks(1);
        queue_item(OP_START, 16'd25, 16'd0, 16'd3, 16'hFFFF);
        queue_ticks(4);
        queue_item(OP_START, 16'd10, 16'd15, 16'd2, 16'd440);
        queue_ticks(8);
        queue_item(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        queue_ticks(2);
        queue_item(OP_START, 16'd5, 16'd5, 16'd0, 16'd777);
        queue_ticks(4);

        // refused starts leave the running pattern alone
        set_regs(10'd1, 1'b0);
        queue_item(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_ticks(1);
        queue_item(OP_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // random phases
        set_regs(10'd1000, 1'b1);
        queue_patterns(60);

        set_regs(10'd1, 1'b1);
        hold_request = 1'b1;
        queue_patterns(60);

        set_regs(10'd0, 1'b1);
        queue_patterns(30);

        set_regs(10'd1023, 1'b1);
        steady = 1'b1;
        queue_patterns(60);
        wait_drained();
        steady = 1'b0;

        // writes to unused indexes must change nothing
        cfg_write(CFG_SPARE_A, 10'($urandom));
        cfg_write(CFG_SPARE_B, 10'($urandom));

        set_regs(10'd37, 1'b0);
        queue_patterns(30);

        set_regs(10'($urandom_range(1000, 1)), 1'b1);
        queue_patterns(50);
        wait_drained();
        queue_patterns(50);

        set_regs(10'($urandom_range(1000, 1)), 1'b1);
        queue_patterns(60);

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("ran %0d items over %0d register settings: %0d starts taken, %0d refused",
                 items_taken, settings_used, starts_taken, starts_refused);
        $display("checked %0d results, %0d mismatches", results_seen, failures);
        if (failures == 0 && expected_tones.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
